// ----- design/assert_macros.svh -----
// assertion macros used by the checker file
// the clock and reset names used here must be ports of the module that expands them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define PFBW_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pfbw check failed");

// checked on every edge, reset included
`define PFBW_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("pfbw check failed during reset");

`endif

// ----- design/pfbw_pkg.sv -----
// shared types and constants for the paged framebuffer pixel writer
// no dependencies; used by every module of the block and by its checker
package pfbw_pkg;

  // parameter defaults
  localparam int PANEL_COLUMNS_DEF = 128;
  localparam int PANEL_ROWS_DEF    = 250;
  localparam int MAX_PAGE_ROWS_DEF = 32;

  // request kinds carried in in_tuser
  localparam int          FUNC_W     = 2;
  localparam logic [1:0]  FUNC_DRAW  = 2'd0;
  localparam logic [1:0]  FUNC_CLEAR = 2'd1;
  localparam logic [1:0]  FUNC_READ  = 2'd2;

  // configuration register indexes
  localparam int          CFG_IDX_W    = 2;
  localparam int          CFG_DATA_W   = 6;
  localparam logic [1:0]  REG_ROTATION = 2'd0;
  localparam logic [1:0]  REG_FLIP     = 2'd1;
  localparam logic [1:0]  REG_ROWS     = 2'd2;
  localparam logic [1:0]  REG_BG       = 2'd3;

  // configuration reset values
  localparam logic [1:0]  RST_ROTATION = 2'd0;
  localparam logic [1:0]  RST_FLIP     = 2'd0;
  localparam logic [5:0]  RST_ROWS     = 6'd16;
  localparam logic [1:0]  RST_BG       = 2'd1;

  // input tdata layout, lowest field first
  localparam int COORD_W   = 11;
  localparam int COLOR_W   = 2;
  localparam int PAGE_W    = 5;
  localparam int BADDR_W   = 9;
  localparam int X_LSB     = 0;
  localparam int Y_LSB     = X_LSB + COORD_W;
  localparam int COLOR_LSB = Y_LSB + COORD_W;
  localparam int PAGE_LSB  = COLOR_LSB + COLOR_W;
  localparam int BADDR_LSB = PAGE_LSB + PAGE_W;
  localparam int PLANE_LSB = BADDR_LSB + BADDR_W;
  localparam int IN_DATA_W = ((PLANE_LSB + 1 + 7) / 8) * 8;
  localparam int OUT_DATA_W = 8;

  // window and panel constants
  localparam int ROW_W       = 9;
  localparam int ROW_LIMIT   = 511;
  localparam int COLUMN_SKIP = 7;
  localparam int CALC_W      = 15;
  localparam logic [7:0] BYTE_ONES = 8'hFF;

  // plane store control
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } pfbw_mem_ctl_t;

endpackage

// ----- design/pfbw_alu.sv -----
// shared add/subtract unit stepped by the sequencer for every coordinate step
// depends on pfbw_pkg for the datapath width
module pfbw_alu (
  input  logic [pfbw_pkg::CALC_W-1:0] a,
  input  logic [pfbw_pkg::CALC_W-1:0] b,
  input  logic                        sub,
  output logic [pfbw_pkg::CALC_W-1:0] sum
);
  import pfbw_pkg::*;

  logic [CALC_W-1:0] b_op;

  // two's complement subtract: invert b and carry in one
  assign b_op = sub ? ~b : b;
  assign sum  = a + b_op + CALC_W'(sub);

endmodule

// ----- design/pfbw_planes.sv -----
// black and red plane stores, one write and one registered read per cycle
// depends on pfbw_pkg for the control struct
module pfbw_planes #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic                  clk,
  input  pfbw_pkg::pfbw_mem_ctl_t ctl,
  input  logic [AW-1:0]         wr_addr,
  input  logic [7:0]            wr_black,
  input  logic [7:0]            wr_red,
  input  logic [AW-1:0]         rd_addr,
  output logic [7:0]            rd_black,
  output logic [7:0]            rd_red
);
  import pfbw_pkg::*;

  logic [7:0] black_mem [DEPTH];
  logic [7:0] red_mem   [DEPTH];
  logic [7:0] rd_black_r;
  logic [7:0] rd_red_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      black_mem[wr_addr] <= wr_black;
      red_mem[wr_addr]   <= wr_red;
    end
    if (ctl.rd_en) begin
      rd_black_r <= black_mem[rd_addr];
      rd_red_r   <= red_mem[rd_addr];
    end
  end

  assign rd_black = rd_black_r;
  assign rd_red   = rd_red_r;

endmodule

// ----- design/paged_framebuffer_pixel_writer_unit.sv -----
// top level of the paged framebuffer pixel writer: sequencer, window and config
// depends on pfbw_pkg, pfbw_alu and pfbw_planes
//
//  channel | direction | handshake               | payload
//  in_     | in        | in_tvalid / in_tready   | in_tuser func, in_tdata request fields
//  out_    | out       | out_tvalid / out_tready | out_tdata read_byte
//  cfg_    | in        | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
//  draw steps through flip, rotate, relative row, row inversion, address, read, write
//  (read and write skipped when the pixel falls outside), each coordinate step is one
//  pass through the shared add/subtract unit; clear computes the page window, then
//  fills the planes one byte per cycle; read waits while the previous result is held
//  rst_n is synchronous; the planes are undefined until the first clear
//  the result register lets a new request in while a read result waits
module paged_framebuffer_pixel_writer_unit #(
  parameter int PANEL_COLUMNS = pfbw_pkg::PANEL_COLUMNS_DEF,
  parameter int PANEL_ROWS    = pfbw_pkg::PANEL_ROWS_DEF,
  parameter int MAX_PAGE_ROWS = pfbw_pkg::MAX_PAGE_ROWS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // func
  input  logic [pfbw_pkg::FUNC_W-1:0]       in_tuser,
  // pixel_x, pixel_y, pixel_color, page_index, byte_address, plane_select, pad
  input  logic [pfbw_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // read_byte
  output logic [pfbw_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pfbw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pfbw_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import pfbw_pkg::*;

  localparam int COL_BYTES   = PANEL_COLUMNS / 8;
  localparam int PLANE_BYTES = MAX_PAGE_ROWS * COL_BYTES;
  localparam int AW          = (PLANE_BYTES > 1) ? $clog2(PLANE_BYTES) : 1;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_FLIPX  = 4'd1;
  localparam logic [3:0] ST_FLIPY  = 4'd2;
  localparam logic [3:0] ST_ROTX   = 4'd3;
  localparam logic [3:0] ST_ROTY   = 4'd4;
  localparam logic [3:0] ST_REL    = 4'd5;
  localparam logic [3:0] ST_ROWINV = 4'd6;
  localparam logic [3:0] ST_ADDR   = 4'd7;
  localparam logic [3:0] ST_RDMEM  = 4'd8;
  localparam logic [3:0] ST_WRMEM  = 4'd9;
  localparam logic [3:0] ST_PAGE   = 4'd10;
  localparam logic [3:0] ST_BOTTOM = 4'd11;
  localparam logic [3:0] ST_SWEEP  = 4'd12;
  localparam logic [3:0] ST_RDREQ  = 4'd13;
  localparam logic [3:0] ST_RDOUT  = 4'd14;
  localparam logic [3:0] ST_FIN    = 4'd15;

  logic [3:0]        state_r, state_nxt;
  logic [1:0]        rot_r, rot_nxt;
  logic [1:0]        flip_r, flip_nxt;
  logic [5:0]        rpp_r, rpp_nxt;
  logic [1:0]        bg_r, bg_nxt;
  logic [ROW_W-1:0]  top_r, top_nxt;
  logic [ROW_W-1:0]  bottom_r, bottom_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_data_r, out_data_nxt;
  logic [CALC_W-1:0] x_r, x_nxt;
  logic [CALC_W-1:0] y_r, y_nxt;
  logic [CALC_W-1:0] rx_r, rx_nxt;
  logic [CALC_W-1:0] ry_r, ry_nxt;
  logic [CALC_W-1:0] rel_r, rel_nxt;
  logic [5:0]        rowinv_r, rowinv_nxt;
  logic [10:0]       topfull_r, topfull_nxt;
  logic [AW-1:0]     addr_r, addr_nxt;
  logic              ok_r, ok_nxt;
  logic [1:0]        color_r, color_nxt;
  logic [PAGE_W-1:0] page_r, page_nxt;
  logic [AW-1:0]     raddr_r, raddr_nxt;
  logic              plane_r, plane_nxt;
  logic              inrange_r, inrange_nxt;
  logic [AW-1:0]     cnt_r, cnt_nxt;

  logic [5:0]        rows;
  logic [5:0]        rows_m1;
  logic [CALC_W-1:0] dw;
  logic [CALC_W-1:0] dh;
  logic [CALC_W-1:0] alu_a, alu_b, alu_sum;
  logic              alu_sub;
  logic              in_fire;
  logic [BADDR_W-1:0] in_baddr;
  logic [7:0]        bit_mask;
  logic [7:0]        rd_black, rd_red;
  logic [7:0]        wr_black, wr_red;
  logic [AW-1:0]     wr_addr, rd_addr;
  pfbw_mem_ctl_t     mem_ctl;

  pfbw_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .sum (alu_sum)
  );

  pfbw_planes #(
    .DEPTH (PLANE_BYTES),
    .AW    (AW)
  ) u_planes (
    .clk      (clk),
    .ctl      (mem_ctl),
    .wr_addr  (wr_addr),
    .wr_black (wr_black),
    .wr_red   (wr_red),
    .rd_addr  (rd_addr),
    .rd_black (rd_black),
    .rd_red   (rd_red)
  );

  // rows per page as used: zero acts as one, large values clamp
  always_comb begin
    if (rpp_r == 6'd0) begin
      rows = 6'd1;
    end else if (32'(rpp_r) > MAX_PAGE_ROWS) begin
      rows = 6'(MAX_PAGE_ROWS);
    end else begin
      rows = rpp_r;
    end
  end

  assign rows_m1   = rows - 6'd1;
  assign dw        = rot_r[0] ? CALC_W'(PANEL_ROWS) : CALC_W'(PANEL_COLUMNS);
  assign dh        = rot_r[0] ? CALC_W'(PANEL_COLUMNS) : CALC_W'(PANEL_ROWS);
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign in_baddr  = in_tdata[BADDR_LSB +: BADDR_W];
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // msb-first bit within the byte
  assign bit_mask = 8'h80 >> rx_r[2:0];

  always_comb begin
    alu_a = '0;
    alu_b = '0;
    alu_sub = 1'b0;
    case (state_r)
      ST_FLIPX: begin
        alu_a = dw;
        alu_b = x_r;
        alu_sub = 1'b1;
      end
      ST_FLIPY: begin
        alu_a = dh;
        alu_b = y_r;
        alu_sub = 1'b1;
      end
      ST_ROTX: begin
        // 90 and 180 mirror x and carry the column skip
        alu_sub = rot_r[0] ^ rot_r[1];
        alu_a = alu_sub ? CALC_W'(PANEL_COLUMNS - COLUMN_SKIP) : '0;
        alu_b = rot_r[0] ? y_r : x_r;
      end
      ST_ROTY: begin
        alu_sub = rot_r[1];
        alu_a = alu_sub ? CALC_W'(PANEL_ROWS - 1) : '0;
        alu_b = rot_r[0] ? x_r : y_r;
      end
      ST_REL: begin
        alu_a = ry_r;
        alu_b = CALC_W'(top_r);
        alu_sub = 1'b1;
      end
      ST_ROWINV: begin
        // rows stored bottom first
        alu_a = CALC_W'(rows_m1);
        alu_b = rel_r;
        alu_sub = 1'b1;
      end
      ST_ADDR: begin
        alu_a = CALC_W'(rowinv_r * COL_BYTES);
        alu_b = {3'b000, rx_r[CALC_W-1:3]};
      end
      ST_BOTTOM: begin
        alu_a = CALC_W'(topfull_r);
        alu_b = CALC_W'(rows_m1);
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    rot_nxt       = rot_r;
    flip_nxt      = flip_r;
    rpp_nxt       = rpp_r;
    bg_nxt        = bg_r;
    top_nxt       = top_r;
    bottom_nxt    = bottom_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    rx_nxt        = rx_r;
    ry_nxt        = ry_r;
    rel_nxt       = rel_r;
    rowinv_nxt    = rowinv_r;
    topfull_nxt   = topfull_r;
    addr_nxt      = addr_r;
    ok_nxt        = ok_r;
    color_nxt     = color_r;
    page_nxt      = page_r;
    raddr_nxt     = raddr_r;
    plane_nxt     = plane_r;
    inrange_nxt   = inrange_r;
    cnt_nxt       = cnt_r;
    mem_ctl       = '0;
    wr_addr       = addr_r;
    wr_black      = (rd_black & ~bit_mask) | (color_r[0] ? bit_mask : 8'h00);
    wr_red        = (rd_red & ~bit_mask) | (color_r[1] ? bit_mask : 8'h00);
    rd_addr       = addr_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROTATION: rot_nxt  = cfg_data[1:0];
        REG_FLIP:     flip_nxt = cfg_data[1:0];
        REG_ROWS:     rpp_nxt  = cfg_data;
        REG_BG:       bg_nxt   = cfg_data[1:0];
        default:      rot_nxt  = rot_r;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          x_nxt = {{(CALC_W-COORD_W){in_tdata[X_LSB+COORD_W-1]}},
                   in_tdata[X_LSB +: COORD_W]};
          y_nxt = {{(CALC_W-COORD_W){in_tdata[Y_LSB+COORD_W-1]}},
                   in_tdata[Y_LSB +: COORD_W]};
          color_nxt   = in_tdata[COLOR_LSB +: COLOR_W];
          page_nxt    = in_tdata[PAGE_LSB +: PAGE_W];
          raddr_nxt   = AW'(in_baddr);
          plane_nxt   = in_tdata[PLANE_LSB];
          inrange_nxt = (32'(in_baddr) < PLANE_BYTES);
          case (in_tuser)
            FUNC_DRAW:  state_nxt = ST_FLIPX;
            FUNC_CLEAR: state_nxt = ST_PAGE;
            FUNC_READ:  state_nxt = ST_RDREQ;
            default:    state_nxt = ST_FIN;
          endcase
        end
      end
      ST_FLIPX: begin
        if (flip_r[0]) x_nxt = alu_sum;
        state_nxt = ST_FLIPY;
      end
      ST_FLIPY: begin
        if (flip_r[1]) y_nxt = alu_sum;
        state_nxt = ST_ROTX;
      end
      ST_ROTX: begin
        rx_nxt = alu_sum;
        state_nxt = ST_ROTY;
      end
      ST_ROTY: begin
        ry_nxt = alu_sum;
        ok_nxt = !rx_r[CALC_W-1] && ($signed(rx_r) < $signed(dw));
        state_nxt = ST_REL;
      end
      ST_REL: begin
        rel_nxt = alu_sum;
        ok_nxt = ok_r && ($signed(ry_r) <= $signed(CALC_W'(bottom_r)));
        state_nxt = ST_ROWINV;
      end
      ST_ROWINV: begin
        rowinv_nxt = alu_sum[5:0];
        ok_nxt = ok_r && !rel_r[CALC_W-1] && (rel_r < CALC_W'(rows));
        state_nxt = ST_ADDR;
      end
      ST_ADDR: begin
        addr_nxt = AW'(alu_sum);
        ok_nxt = ok_r && !alu_sum[CALC_W-1] && (32'(alu_sum) < PLANE_BYTES);
        state_nxt = ST_RDMEM;
      end
      ST_RDMEM: begin
        if (ok_r) begin
          mem_ctl.rd_en = 1'b1;
          state_nxt = ST_WRMEM;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_WRMEM: begin
        mem_ctl.wr_en = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_PAGE: begin
        topfull_nxt = 11'(page_r * rows);
        state_nxt = ST_BOTTOM;
      end
      ST_BOTTOM: begin
        // window past the row limit saturates, or collapses when the top is past it
        if (32'(topfull_r) > ROW_LIMIT) begin
          top_nxt = ROW_W'(ROW_LIMIT);
          bottom_nxt = '0;
        end else if (32'(alu_sum) > ROW_LIMIT) begin
          top_nxt = topfull_r[ROW_W-1:0];
          bottom_nxt = ROW_W'(ROW_LIMIT);
        end else begin
          top_nxt = topfull_r[ROW_W-1:0];
          bottom_nxt = alu_sum[ROW_W-1:0];
        end
        cnt_nxt = '0;
        state_nxt = ST_SWEEP;
      end
      ST_SWEEP: begin
        mem_ctl.wr_en = 1'b1;
        wr_addr = cnt_r;
        wr_black = bg_r[0] ? BYTE_ONES : 8'h00;
        wr_red = bg_r[1] ? BYTE_ONES : 8'h00;
        cnt_nxt = cnt_r + AW'(1);
        if (cnt_r == AW'(PLANE_BYTES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RDREQ: begin
        mem_ctl.rd_en = inrange_r;
        rd_addr = raddr_r;
        state_nxt = ST_RDOUT;
      end
      ST_RDOUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt = !inrange_r ? 8'h00 : (plane_r ? rd_red : rd_black);
          state_nxt = ST_IDLE;
        end
      end
      ST_FIN: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rot_r       <= RST_ROTATION;
      flip_r      <= RST_FLIP;
      rpp_r       <= RST_ROWS;
      bg_r        <= RST_BG;
      top_r       <= '0;
      bottom_r    <= ROW_W'(RST_ROWS) - ROW_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rot_r       <= rot_nxt;
      flip_r      <= flip_nxt;
      rpp_r       <= rpp_nxt;
      bg_r        <= bg_nxt;
      top_r       <= top_nxt;
      bottom_r    <= bottom_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    rx_r       <= rx_nxt;
    ry_r       <= ry_nxt;
    rel_r      <= rel_nxt;
    rowinv_r   <= rowinv_nxt;
    topfull_r  <= topfull_nxt;
    addr_r     <= addr_nxt;
    ok_r       <= ok_nxt;
    color_r    <= color_nxt;
    page_r     <= page_nxt;
    raddr_r    <= raddr_nxt;
    plane_r    <= plane_nxt;
    inrange_r  <= inrange_nxt;
    cnt_r      <= cnt_nxt;
  end

endmodule

// ----- design/pfbw_checker.sv -----
// port-level checks for the paged framebuffer pixel writer, bound to the top level
// depends on pfbw_pkg and assert_macros.svh
`include "assert_macros.svh"

module pfbw_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [pfbw_pkg::FUNC_W-1:0]     in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [pfbw_pkg::OUT_DATA_W-1:0] out_tdata
);
  import pfbw_pkg::*;

  // reset leaves no result pending and the block ready
  `PFBW_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (!out_tvalid && in_tready))

  // every accepted request keeps the sequencer busy in the cycle after it is accepted
  `PFBW_ASSERT(a_busy_after_accept, (in_tvalid && in_tready) |=> !in_tready)

  // a clear computes its window before the sweep, so it is busy through its page and bottom steps at least
  `PFBW_ASSERT(a_clear_busy, (in_tvalid && in_tready && in_tuser == FUNC_CLEAR) |=> !in_tready ##1 !in_tready)

  // a new result only appears right after the sequencer was busy with a read
  `PFBW_ASSERT(a_result_from_busy, $rose(out_tvalid) |-> $past(!in_tready))

  // a held result does not change
  `PFBW_ASSERT(a_out_hold, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))

endmodule

bind paged_framebuffer_pixel_writer_unit pfbw_checker u_pfbw_checker (.*);
